// ===== design/bsb_pkg.sv =====
// Shared types and constants of the 3x3 box smoothing and binarization block.
`default_nettype none

package bsb_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam int WREG_W = 9;
	localparam int HREG_W = 10;
	// Row counter runs to the frame height plus one while the frame drains.
	localparam int ROW_W  = 11;
	localparam logic [WREG_W-1:0] WIDTH_RESET  = 9'd202;
	localparam logic [HREG_W-1:0] HEIGHT_RESET = 10'd42;

	// Arithmetic
	localparam logic [7:0] BG_PIXEL = 8'd255;
	localparam int CSUM_W = 10;
	localparam logic [CSUM_W-1:0] BG_COLUMN = 10'd765;
	localparam int SUM_W = 12;
	localparam logic [SUM_W-1:0] BLACK_SUM = 12'd2295;

	// Line buffer entry holds the upper row pixel above the lower row pixel.
	localparam int LINE_W = 16;

	localparam int QUEUE_DEPTH = 4;

	// Classified word passed from the front end to the back end.
	typedef struct packed {
		logic [7:0] fresh;
		logic       emit;
		logic       last;
		logic       col_first;
		logic       col_second;
		logic       single_col;
		logic       upper_ok;
		logic       lower_ok;
	} bsb_word_t;

endpackage

`default_nettype wire

// ===== design/bsb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== design/bsb_fifo.sv =====
// Short flip-flop queue between the front end and the back end.
`default_nettype none

module bsb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bsb_front.sv =====
// Front end: configuration registers, frame position tracking and word classification.
`default_nettype none

module bsb_front #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [7:0]                     pixel_value,
	input  logic                           q_full,
	output logic                           q_push,
	output logic [$clog2(MAX_WIDTH)-1:0]   push_col,
	output bsb_pkg::bsb_word_t             push_word,
	output logic                           restart
);

	import bsb_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW    = $clog2(MAX_WIDTH + 1);
	localparam int CNT_W = EW + HREG_W;

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [EW-1:0]     eff_w;
	logic [HREG_W-1:0] eff_h;
	logic [CNT_W-1:0]  area;
	logic [CNT_W-1:0]  total_m1_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_h;
	logic [COL_W:0]    col_inc;
	logic              wrap;
	logic              accept;
	logic              emit;
	logic              last;

	always_comb begin
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
	end

	assign eff_h = (height_q == '0) ? HREG_W'(1) : height_q;
	assign area  = CNT_W'(eff_w) * CNT_W'(eff_h);

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid &&
		(cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	assign row_h   = ROW_W'(eff_h);
	assign col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
	assign wrap    = (col_inc >= (COL_W + 1)'(eff_w));
	assign emit    = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
	assign last    = emit && (out_cnt_q == total_m1_q);

	// Flush items and anything past the bottom row bring in background.
	always_comb begin
		push_word.fresh      = (row_q < row_h && !action) ? pixel_value : BG_PIXEL;
		push_word.emit       = emit;
		push_word.last       = last;
		push_word.col_first  = (col_q == '0);
		push_word.col_second = (col_q == COL_W'(1));
		push_word.single_col = (eff_w == EW'(1));
		push_word.upper_ok   = (row_q >= ROW_W'(2)) && (row_q <= row_h + ROW_W'(1));
		push_word.lower_ok   = (row_q != '0) && (row_q <= row_h);
	end

	assign push_col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			total_m1_q <= '0;
			out_cnt_q  <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			total_m1_q <= area - CNT_W'(1);
			if (cfg_valid && cfg_index == CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WREG_W-1:0];
			end
			if (cfg_valid && cfg_index == CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HREG_W-1:0];
			end
			if (restart) begin
				out_cnt_q <= '0;
				col_q     <= '0;
				row_q     <= '0;
			end else if (accept) begin
				if (last) begin
					out_cnt_q <= '0;
					col_q     <= '0;
					row_q     <= '0;
				end else begin
					if (wrap) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_inc[COL_W-1:0];
					end
					if (emit) begin
						out_cnt_q <= out_cnt_q + CNT_W'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bsb_back.sv =====
// Back end: line buffer, column-sum window, threshold and output register.
`default_nettype none

module bsb_back #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         q_not_empty,
	input  logic [$clog2(MAX_WIDTH)-1:0] head_col,
	input  bsb_pkg::bsb_word_t           head_word,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         binary_pixel,
	output logic                         last_of_frame
);

	import bsb_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic              adv;
	logic              proc;
	logic              s1_valid_q;
	bsb_word_t         word_s1;
	logic [COL_W-1:0]  col_s1;
	logic              byp_q;
	logic [LINE_W-1:0] byp_data_q;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_cur;
	logic [LINE_W-1:0] line_wr;
	logic [7:0]        upper;
	logic [7:0]        lower;
	logic [CSUM_W-1:0] sn;
	logic [CSUM_W-1:0] sc1_q;
	logic [CSUM_W-1:0] sc2_q;
	logic [CSUM_W-1:0] ta;
	logic [CSUM_W-1:0] tc;
	logic [SUM_W-1:0]  sum;
	logic              out_valid_q;
	logic              binary_q;
	logic              last_q;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_not_empty;
	assign proc  = adv && s1_valid_q;

	bsb_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.wr_en   (proc),
		.wr_addr (col_s1),
		.wr_data (line_wr),
		.rd_en   (q_pop),
		.rd_addr (head_col),
		.rd_data (line_rd)
	);

	// With a one-pixel row the next word reads the column written this cycle.
	assign line_cur = byp_q ? byp_data_q : line_rd;
	assign upper    = word_s1.upper_ok ? line_cur[15:8] : BG_PIXEL;
	assign lower    = word_s1.lower_ok ? line_cur[7:0] : BG_PIXEL;
	assign line_wr  = {line_cur[7:0], word_s1.fresh};

	assign sn = CSUM_W'(upper) + CSUM_W'(lower) + CSUM_W'(word_s1.fresh);

	// The window keeps column sums. At the first column of a row the result
	// belongs to the last pixel of the row before, whose right edge is outside.
	assign ta  = ((word_s1.col_first && word_s1.single_col) || word_s1.col_second) ?
		BG_COLUMN : sc1_q;
	assign tc  = word_s1.col_first ? BG_COLUMN : sn;
	assign sum = SUM_W'(ta) + SUM_W'(sc2_q) + SUM_W'(tc);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_s1    <= head_word;
			col_s1     <= head_col;
			byp_data_q <= line_wr;
		end
		if (proc) begin
			binary_q <= (sum < BLACK_SUM);
			last_q   <= word_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
			sc1_q       <= BG_COLUMN;
			sc2_q       <= BG_COLUMN;
		end else begin
			if (adv) begin
				s1_valid_q  <= q_not_empty;
				out_valid_q <= proc && word_s1.emit;
			end
			if (q_pop) begin
				byp_q <= proc && (head_col == col_s1);
			end
			if (restart || (proc && word_s1.last)) begin
				sc1_q <= BG_COLUMN;
				sc2_q <= BG_COLUMN;
			end else if (proc) begin
				sc1_q <= sc2_q;
				sc2_q <= sn;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign binary_pixel  = binary_q;
	assign last_of_frame = last_q;

endmodule

`default_nettype wire

// ===== design/box_smooth_binarize_3x3_top.sv =====
// Path: the word that completes a neighborhood (pixel p completes with word p + W + 1)
// passes the queue and stage-one register; its result is held in the output register.
// Throughput: one word per cycle while not stalled, set by a line buffer RAM read and
// write per column; a four-word queue decouples the input side from output stalls.
// Reset: asynchronous, active low; width 202 and height 42, window at background,
// line buffer contents are not cleared and are never used before being written.
`default_nettype none

module box_smooth_binarize_3x3_top #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [7:0]                     pixel_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           binary_pixel,
	output logic                           last_of_frame
);

	import bsb_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int QW    = COL_W + $bits(bsb_word_t);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_not_empty;
	logic             restart;
	logic [COL_W-1:0] push_col;
	bsb_word_t        push_word;
	logic [QW-1:0]    head_data;
	logic [COL_W-1:0] head_col;
	bsb_word_t        head_word;

	bsb_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.q_push      (q_push),
		.push_col    (push_col),
		.push_word   (push_word),
		.restart     (restart)
	);

	bsb_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_col, push_word}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (head_data)
	);

	assign head_col  = head_data[QW-1 -: COL_W];
	assign head_word = head_data[$bits(bsb_word_t)-1:0];

	bsb_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.q_not_empty   (q_not_empty),
		.head_col      (head_col),
		.head_word     (head_word),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.binary_pixel  (binary_pixel),
		.last_of_frame (last_of_frame)
	);

	// The back end never pops a word that is not there.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_not_empty)
		else $error("queue popped while empty");

	// An accepted word is in the queue at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> q_not_empty)
		else $error("accepted word missing from queue");

	// The word after a frame's last one opens a new frame and never gives a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_frame |=> !out_valid)
		else $error("result directly after end of frame");

endmodule

`default_nettype wire
